FILE: rtl/ppb_crc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_crc_pkg: shared types, constants and functions
// Widths, the reset polynomial, controller/datapath bundles and the
// single-bit polynomial reduction step used by the datapath.
// ----------------------------------------------------------------------------
package ppb_crc_pkg;

    // field widths
    localparam int DATA_W = 8;
    localparam int CRC_W  = 16;
    localparam int POLY_W = CRC_W + 1;
    localparam int DEG_W  = $clog2(POLY_W);
    localparam int ACC_W  = 2 * CRC_W;

    // largest degree that is reduced, above it the result is zero
    localparam int MAX_DEGREE = 16;

    // polynomial after reset
    localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(17'h18005);

    // two dividend bits are consumed per step cycle
    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = ACC_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS);

    // controller to datapath commands
    typedef struct packed {
        logic load;          // capture a request and build the dividend
        logic step;          // shift two dividend bits into the remainder
        logic finish;        // store the final remainder as running state
        logic out_load;      // write the output register
        logic out_from_run;  // output source is the stored running remainder
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;          // current request closes a message
    } t_status;

    // index of the top set bit, zero for an all-zero word
    function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] p);
        logic [DEG_W-1:0] d;
        d = '0;
        for (int i = 0; i < POLY_W; i++) begin
            if (p[i]) begin
                d = DEG_W'(i);
            end
        end
        return d;
    endfunction

    // shift one dividend bit into the remainder and reduce by the polynomial
    function automatic logic [CRC_W-1:0] crc_step(
        input logic [CRC_W-1:0]  rem,
        input logic              din,
        input logic [POLY_W-1:0] poly,
        input logic [DEG_W-1:0]  deg
    );
        logic [POLY_W-1:0] t;
        t = {rem, din};
        if (t[deg]) begin
            t = t ^ poly;
        end
        return t[CRC_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ppb_crc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_crc_ctrl: sequencing state machine
// Accepts one request and runs the step counter over the dividend; a result
// that closes a message goes to the output register or waits until it is free.
// ----------------------------------------------------------------------------
module ppb_crc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  ppb_crc_pkg::t_status i_status,
    output ppb_crc_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    localparam logic [ppb_crc_pkg::CNT_W-1:0] CNT_LAST =
        ppb_crc_pkg::CNT_W'(ppb_crc_pkg::STEPS - 1);

    logic [1:0]                    r_state, n_state;
    logic [ppb_crc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          w_out_free;

    // output register can take a new result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_status.last) begin
                        if (w_out_free) begin
                            o_cmd.out_load = 1'b1;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_run = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ppb_crc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_crc_dp: remainder datapath
// Holds the polynomial register, the running remainder, the dividend shift
// register and the bit-serial reducer, plus the output register.
// ----------------------------------------------------------------------------
module ppb_crc_dp #(
    parameter int MAX_DEGREE = ppb_crc_pkg::MAX_DEGREE
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [ppb_crc_pkg::POLY_W-1:0]      i_cfg_data,
    input  wire [ppb_crc_pkg::DATA_W-1:0]      i_data_byte,
    input  wire                                i_first_byte,
    input  wire                                i_last_byte,
    input  ppb_crc_pkg::t_cmd                  i_cmd,
    output ppb_crc_pkg::t_status               o_status,
    output logic [ppb_crc_pkg::CRC_W-1:0]      o_crc_value
);

    localparam logic [ppb_crc_pkg::DEG_W-1:0] DEG_MAX =
        ppb_crc_pkg::DEG_W'(MAX_DEGREE);

    logic [ppb_crc_pkg::POLY_W-1:0] r_poly;
    logic [ppb_crc_pkg::CRC_W-1:0]  r_run;
    logic [ppb_crc_pkg::ACC_W-1:0]  r_shift;
    logic [ppb_crc_pkg::CRC_W-1:0]  r_rem;
    logic [ppb_crc_pkg::POLY_W-1:0] r_g;
    logic [ppb_crc_pkg::DEG_W-1:0]  r_deg;
    logic                           r_ok;
    logic                           r_last;
    logic [ppb_crc_pkg::CRC_W-1:0]  r_out;

    logic [ppb_crc_pkg::DEG_W-1:0]  w_deg;
    logic                           w_ok;
    logic [ppb_crc_pkg::CRC_W-1:0]  w_base;
    logic [ppb_crc_pkg::ACC_W-1:0]  w_dividend;
    logic [ppb_crc_pkg::CRC_W-1:0]  w_rem_mid;
    logic [ppb_crc_pkg::CRC_W-1:0]  n_rem;
    logic [ppb_crc_pkg::CRC_W-1:0]  w_final;

    // degree of the programmed polynomial, zero polynomial gives a zero result
    assign w_deg = ppb_crc_pkg::poly_degree(r_poly);
    assign w_ok  = (r_poly != '0) && (w_deg <= DEG_MAX);

    // dividend: running remainder times x^d, data byte added in
    assign w_base     = i_first_byte ? '0 : r_run;
    assign w_dividend = ({{ppb_crc_pkg::CRC_W{1'b0}}, w_base} << w_deg)
                      ^ ppb_crc_pkg::ACC_W'(i_data_byte);

    // two reduction steps per cycle, top dividend bits first
    assign w_rem_mid = ppb_crc_pkg::crc_step(r_rem, r_shift[ppb_crc_pkg::ACC_W-1],
                                             r_g, r_deg);
    assign n_rem     = ppb_crc_pkg::crc_step(w_rem_mid, r_shift[ppb_crc_pkg::ACC_W-2],
                                             r_g, r_deg);
    assign w_final   = r_ok ? n_rem : '0;

    assign o_status.last = r_last;
    assign o_crc_value   = r_out;

    // polynomial register and running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= ppb_crc_pkg::POLY_RESET;
            r_run  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_poly <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_run <= w_final;
            end
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= w_dividend;
            r_rem   <= '0;
            r_g     <= r_poly;
            r_deg   <= w_deg;
            r_ok    <= w_ok;
            r_last  <= i_last_byte;
        end else if (i_cmd.step) begin
            r_shift <= r_shift << ppb_crc_pkg::BITS_PER_STEP;
            r_rem   <= n_rem;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= i_cmd.out_from_run ? r_run : w_final;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/programmable_poly_byte_crc.sv
// Programmable-polynomial byte hash.
// Input channel: i_in_valid / o_in_ready carry one request per byte with
// i_data_byte, i_first_byte (clear the remainder first) and i_last_byte.
// Output channel: o_out_valid / i_out_ready carry o_crc_value, one result
// per request that has i_last_byte set, none for the others.
// Configuration: i_cfg_we writes i_cfg_data into the 17-bit generator
// polynomial, effective for the next request; write it only while idle.
// Sequence: a request is accepted, then stepped by the bit-serial reducer,
// which consumes two of the 32 dividend bits per cycle. o_out_valid rises
// after the last step, and the next request can be accepted in that same
// cycle.
// Stall: a result waits in the output register; the next request is still
// accepted and processed, and if it closes a message while the register is
// full its result is held and no request is taken until the register frees.
// Reset: synchronous, active low; clears the remainder, drops o_out_valid
// and loads the polynomial 0x18005.
// ----------------------------------------------------------------------------
// programmable_poly_byte_crc: top level
// Joins the sequencing controller and the remainder datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module programmable_poly_byte_crc #(
    parameter int MAX_DEGREE = ppb_crc_pkg::MAX_DEGREE
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ppb_crc_pkg::POLY_W-1:0]     i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [ppb_crc_pkg::DATA_W-1:0]     i_data_byte,
    input  wire                               i_first_byte,
    input  wire                               i_last_byte,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [ppb_crc_pkg::CRC_W-1:0]     o_crc_value
);

    ppb_crc_pkg::t_cmd    w_cmd;
    ppb_crc_pkg::t_status w_status;

    // sequencing
    ppb_crc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // remainder arithmetic
    ppb_crc_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_crc_value  (o_crc_value)
    );

`ifndef SYNTHESIS
    // a load happens only on an accepted request
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in_valid && o_in_ready))
        else $error("load without accepted request");

    // no new request while the reducer is stepping
    a_busy_while_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !o_in_ready)
        else $error("ready while stepping");

    // a result never overwrites one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");

    // an accepted request is followed by stepping
    a_step_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.step)
        else $error("no step after load");
`endif

endmodule
`default_nettype wire

FILE: bench/programmable_poly_byte_crc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_poly_byte_crc_tb: self-checking bench for the byte hash
// Feeds byte requests under a series of generator polynomials, predicts the
// remainder after each request over GF(2) and compares every emitted crc
// value in order; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module programmable_poly_byte_crc_tb;

    localparam int DATA_W     = ppb_crc_pkg::DATA_W;
    localparam int CRC_W      = ppb_crc_pkg::CRC_W;
    localparam int POLY_W     = ppb_crc_pkg::POLY_W;
    localparam int MAX_DEGREE = ppb_crc_pkg::MAX_DEGREE;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 400;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 175;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
        logic              last;
    } t_byte_req;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [POLY_W-1:0] i_cfg_data   = '0;
    logic              i_in_valid   = 1'b0;
    logic [DATA_W-1:0] i_data_byte  = '0;
    logic              i_first_byte = 1'b0;
    logic              i_last_byte  = 1'b0;
    logic              i_out_ready  = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [CRC_W-1:0]  o_crc_value;

    t_byte_req         pending_q[$];
    logic [CRC_W-1:0]  crc_expect_q[$];
    logic [POLY_W-1:0] model_poly = ppb_crc_pkg::POLY_RESET;
    logic [CRC_W-1:0]  model_rem  = '0;
    logic              offer_taken = 1'b0;
    logic              long_hold_req = 1'b0;
    int                err_count = 0;
    int                cycle_count = 0;

    programmable_poly_byte_crc DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_crc_value  (o_crc_value)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // a mod g over GF(2), g of degree deg >= 0
    function automatic logic [CRC_W-1:0] gf2_mod(input logic [31:0] a,
                                                 input logic [POLY_W-1:0] g,
                                                 input int deg);
        logic [47:0] acc;
        acc = {16'h0, a};
        for (int i = 31; i >= 0; i--) begin
            if (i >= deg && acc[i]) begin
                acc = acc ^ ({31'h0, g} << (i - deg));
            end
        end
        return acc[CRC_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [CRC_W-1:0] got,
                                   input logic [CRC_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    task automatic push_req(input logic [7:0] data, input logic first, input logic last);
        t_byte_req req;
        req.data  = data;
        req.first = first;
        req.last  = last;
        pending_q.push_back(req);
    endtask

    // wait until every request is taken and every crc has come, then let
    // a request without a result finish inside the block
    task automatic wait_idle();
        while (pending_q.size() != 0 || i_in_valid || crc_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_poly(input logic [POLY_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        model_poly = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one random message, or a short run of loose requests now and then
    task automatic push_message(output int count);
        int len;
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                push_req(8'($urandom_range(0, 255)), i == 0, i == len - 1);
            end
        end
        count = len;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // request driver, bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || offer_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                i_in_valid   <= 1'b1;
                i_data_byte  <= pending_q[0].data;
                i_first_byte <= pending_q[0].first;
                i_last_byte  <= pending_q[0].last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        offer_taken = 1'b0;
    end

    // accepted request: advance the remainder and queue the crc it closes
    always @(posedge i_clk) begin : accept_blk
        t_byte_req        req;
        int               deg;
        logic [CRC_W-1:0] rem;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            req = pending_q.pop_front();
            offer_taken = 1'b1;
            deg = -1;
            for (int i = 0; i < POLY_W; i++) begin
                if (model_poly[i]) begin
                    deg = i;
                end
            end
            rem = req.first ? '0 : model_rem;
            // zero polynomial or one above the largest degree gives zero
            if (deg < 0 || deg > MAX_DEGREE) begin
                rem = '0;
            end else begin
                rem = gf2_mod({16'h0, rem} << deg, model_poly, deg)
                    ^ gf2_mod({24'h0, req.data}, model_poly, deg);
            end
            model_rem = rem;
            if (req.last) begin
                crc_expect_q.push_back(rem);
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int        hold_left = 0;
    int        pat_age   = 0;
    logic [7:0] stall_pat = 8'hFF;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            pat_age++;
            if (pat_age >= 50) begin
                pat_age = 0;
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                        : (8'($urandom_range(0, 255)) | 8'h01);
            end
            stall_pat = {stall_pat[6:0], stall_pat[7]};
            i_out_ready <= stall_pat[0];
        end
    end

    // crc monitor
    always @(posedge i_clk) begin : monitor_blk
        logic [CRC_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (crc_expect_q.size() == 0) begin
                report_mismatch("crc with no request closing a message", o_crc_value, '0);
            end else begin
                want = crc_expect_q.pop_front();
                if (o_crc_value !== want) begin
                    report_mismatch("crc_value", o_crc_value, want);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stim_blk
        int phase_count;
        int n;
        int deg;
        logic [POLY_W-1:0] poly;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset polynomial: single-byte messages, a full message, then a
        // message with no first byte that carries the old remainder on
        push_req(8'h00, 1'b1, 1'b1);
        push_req(8'hFF, 1'b1, 1'b1);
        push_req(8'h80, 1'b1, 1'b1);
        push_req(8'h01, 1'b1, 1'b0);
        push_req(8'hAA, 1'b0, 1'b0);
        push_req(8'h55, 1'b0, 1'b1);
        push_req(8'h3C, 1'b0, 1'b1);
        push_req(8'hC3, 1'b1, 1'b0);
        wait_idle();

        // zero polynomial
        write_poly('0);
        push_req(8'h5A, 1'b0, 1'b1);
        push_req(8'hA5, 1'b1, 1'b1);
        wait_idle();

        // degree zero
        write_poly(17'h00001);
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h12, 1'b0, 1'b1);
        wait_idle();

        // all ones, degree sixteen
        write_poly(17'h1FFFF);
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'h7E, 1'b0, 1'b1);
        wait_idle();

        // bare x^16, message left open
        write_poly(17'h10000);
        push_req(8'hFF, 1'b1, 1'b1);
        push_req(8'h81, 1'b1, 1'b0);
        wait_idle();

        // polynomial changed in mid-message
        write_poly(17'h00003);
        push_req(8'hF0, 1'b0, 1'b1);
        wait_idle();

        write_poly(17'h00107);
        push_req(8'hEE, 1'b1, 1'b1);
        wait_idle();

        // random messages under several polynomials
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                poly = ppb_crc_pkg::POLY_RESET;
            end else if (p == 2) begin
                poly = 17'h1FFFF;
            end else if (p == 5) begin
                poly = '0;
            end else begin
                deg  = $urandom_range(0, 16);
                poly = (POLY_W'(1) << deg) | (POLY_W'($urandom) & ((POLY_W'(1) << deg) - 1));
            end
            write_poly(poly);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                push_message(n);
                phase_count += n;
            end
            // receiver holds off while requests keep coming
            if (p == 3) begin
                long_hold_req = 1'b1;
            end
            wait_idle();
        end

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
